FILE: hdl/evs_pkg.sv
package evs_pkg;

	localparam int SLOTS_DEF     = 32;
	localparam int ID_BITS_DEF   = 8;
	localparam int TIME_BITS_DEF = 48;

	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 7;

	typedef enum logic [KIND_W-1:0] {
		K_SCHED  = 3'd0,
		K_REMOVE = 3'd1,
		K_ADJUST = 3'd2,
		K_FIND   = 3'd3,
		K_HANDLE = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// control part of the token that walks the cell chain
	typedef struct packed {
		logic  active;
		kind_t op;
		logic  list;
		logic  pass2;
		logic  found;
	} evs_ctl_t;

endpackage

FILE: hdl/evs_in_if.sv
interface evs_in_if #(
	parameter int ID_BITS   = 8,
	parameter int TIME_BITS = 48
);
	logic                        valid;
	logic                        ready;
	logic [2:0]                  kind;
	logic                        list_sel;
	logic [ID_BITS-1:0]          event_id;
	logic signed [TIME_BITS-1:0] event_time;

	modport source (output valid, kind, list_sel, event_id, event_time, input ready);
	modport sink   (input valid, kind, list_sel, event_id, event_time, output ready);
endinterface

FILE: hdl/evs_out_if.sv
interface evs_out_if #(
	parameter int ID_BITS   = 8,
	parameter int TIME_BITS = 48
);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [4:0]                  slot_index;
	logic signed [TIME_BITS-1:0] next_time;
	logic [ID_BITS-1:0]          fired_id;
	logic [6:0]                  pending_count;

	modport source (output valid, status, slot_index, next_time, fired_id, pending_count,
		input ready);
	modport sink   (input valid, status, slot_index, next_time, fired_id, pending_count,
		output ready);
endinterface

FILE: hdl/evs_cell.sv
module evs_cell #(
	parameter int SLOTS     = 32,
	parameter int ID_BITS   = 8,
	parameter int TIME_BITS = 48,
	parameter int IDX       = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  evs_pkg::evs_ctl_t                      ctl_i,
	input  logic [ID_BITS-1:0]                     id_i,
	input  logic signed [TIME_BITS-1:0]            time_i,
	input  logic [$clog2(SLOTS)-1:0]               target_i,
	input  logic [$clog2(SLOTS)-1:0]               best_idx_i,
	input  logic signed [TIME_BITS-1:0]            best_time_i,
	input  logic [ID_BITS-1:0]                     fired_i,
	output evs_pkg::evs_ctl_t                      ctl_o,
	output logic [ID_BITS-1:0]                     id_o,
	output logic signed [TIME_BITS-1:0]            time_o,
	output logic [$clog2(SLOTS)-1:0]               target_o,
	output logic [$clog2(SLOTS)-1:0]               best_idx_o,
	output logic signed [TIME_BITS-1:0]            best_time_o,
	output logic [ID_BITS-1:0]                     fired_o
);
	import evs_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
	localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

	// slot pair held by this cell: entry 0 main list, entry 1 secondary list
	logic [1:0]                  v_q, v_n;
	logic [ID_BITS-1:0]          id_q [2];
	logic [ID_BITS-1:0]          id_n [2];
	logic signed [TIME_BITS-1:0] time_q [2];
	logic signed [TIME_BITS-1:0] time_n [2];

	evs_ctl_t                    ctl_n;
	logic [IDX_W-1:0]            best_idx_n;
	logic signed [TIME_BITS-1:0] best_time_n;
	logic [ID_BITS-1:0]          fired_n;
	logic                        sel, hit0, hit1;
	logic [TIME_BITS:0]          diff;
	logic signed [TIME_BITS-1:0] sat;

	assign sel  = ctl_i.list;
	assign hit0 = v_q[0] && (id_q[0] == id_i);
	assign hit1 = v_q[1] && (id_q[1] == id_i);

	// saturating subtract of the elapsed time
	assign diff = {time_q[sel][TIME_BITS-1], time_q[sel]}
		- {best_time_i[TIME_BITS-1], best_time_i};
	assign sat  = (diff[TIME_BITS] != diff[TIME_BITS-1])
		? (diff[TIME_BITS] ? T_MIN : T_MAX) : diff[TIME_BITS-1:0];

	// per-cell operation on the passing token
	always_comb begin
		ctl_n       = ctl_i;
		best_idx_n  = best_idx_i;
		best_time_n = best_time_i;
		fired_n     = fired_i;
		v_n         = v_q;
		id_n        = id_q;
		time_n      = time_q;
		if (ctl_i.active) begin
			case (ctl_i.op)
				K_SCHED: begin
					if (!ctl_i.found && !v_q[sel]) begin
						v_n[sel]    = 1'b1;
						id_n[sel]   = id_i;
						time_n[sel] = time_i;
						ctl_n.found = 1'b1;
						best_idx_n  = MY_IDX;
					end
				end
				K_REMOVE, K_ADJUST: begin
					if (!ctl_i.found && (hit0 || hit1)) begin
						ctl_n.found = 1'b1;
						best_idx_n  = MY_IDX;
						if (ctl_i.op == K_REMOVE) begin
							v_n[hit0 ? 1'b0 : 1'b1] = 1'b0;
						end else begin
							time_n[hit0 ? 1'b0 : 1'b1] = time_i;
						end
					end
				end
				K_FIND: begin
					if (v_q[sel] && (!ctl_i.found || time_q[sel] < best_time_i)) begin
						ctl_n.found = 1'b1;
						best_idx_n  = MY_IDX;
						best_time_n = time_q[sel];
					end
				end
				K_HANDLE: begin
					if (!ctl_i.pass2) begin
						if (target_i == MY_IDX && v_q[sel]) begin
							ctl_n.found = 1'b1;
							best_time_n = time_q[sel];
							fired_n     = id_q[sel];
						end
					end else begin
						if (v_q[sel]) time_n[sel] = sat;
						if (target_i == MY_IDX) v_n[sel] = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			ctl_o <= '0;
		end else begin
			v_q   <= v_n;
			ctl_o <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		id_q        <= id_n;
		time_q      <= time_n;
		id_o        <= id_i;
		time_o      <= time_i;
		target_o    <= target_i;
		best_idx_o  <= best_idx_n;
		best_time_o <= best_time_n;
		fired_o     <= fired_n;
	end

endmodule

FILE: hdl/event_slot_scheduler_core.sv
// Event slot scheduler: two lists of SLOTS pending events (main, secondary).
// req (sink): one transaction per command - schedule, remove, adjust time,
//   find next, handle next - with list_sel, event_id and event_time.
// rsp (source): exactly one transaction per command with status, slot_index,
//   next_time, fired_id and the pending count after the command.
// Each command travels as a token down a row of SLOTS cells, one cell per
// cycle; every cell holds slot i of both lists. The result is collected at the
// end of the row and then loaded into the output register; a handle that
// releases an event walks the row twice (look up the elapsed time, then
// subtract it). Unused kinds skip the row. One command is in the row at a
// time; the next req is taken in the cycle after the response is loaded.
// req.ready is high only while the row is free. A finished response sits in
// the output register, so the next command is taken while rsp is stalled;
// a second response waits internally and req stays low until it moves out.
// Reset clears all slot valid bits, the remembered next slots and the
// pending count; slot times and identifiers are not cleared.
module event_slot_scheduler_core #(
	parameter int SLOTS     = evs_pkg::SLOTS_DEF,
	parameter int ID_BITS   = evs_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = evs_pkg::TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	evs_in_if.sink    req,
	evs_out_if.source rsp
);
	import evs_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(2 * SLOTS + 1);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

	state_t                      state_q;
	logic [IDX_W-1:0]            next_main_q, next_sec_q;
	logic [CNT_W-1:0]            cnt_q;

	// token chain, entry 0 is the launch register
	evs_ctl_t                    ctl_c       [SLOTS+1];
	logic [ID_BITS-1:0]          id_c        [SLOTS+1];
	logic signed [TIME_BITS-1:0] time_c      [SLOTS+1];
	logic [IDX_W-1:0]            target_c    [SLOTS+1];
	logic [IDX_W-1:0]            best_idx_c  [SLOTS+1];
	logic signed [TIME_BITS-1:0] best_time_c [SLOTS+1];
	logic [ID_BITS-1:0]          fired_c     [SLOTS+1];

	evs_ctl_t                    launch_ctl_q;
	logic [ID_BITS-1:0]          launch_id_q, launch_fired_q;
	logic signed [TIME_BITS-1:0] launch_time_q, launch_best_time_q;
	logic [IDX_W-1:0]            launch_target_q;

	// staged result and output register
	status_t                     res_status_q;
	logic [IDX_W-1:0]            res_idx_q;
	logic signed [TIME_BITS-1:0] res_time_q;
	logic [ID_BITS-1:0]          res_fired_q;
	logic                        out_valid_q;
	status_t                     out_status_q;
	logic [IDX_W-1:0]            out_idx_q;
	logic signed [TIME_BITS-1:0] out_time_q;
	logic [ID_BITS-1:0]          out_fired_q;
	logic [CNT_W-1:0]            out_cnt_q;

	evs_ctl_t                    end_ctl;
	logic                        accept;
	kind_t                       in_kind;

	assign ctl_c[0]       = launch_ctl_q;
	assign id_c[0]        = launch_id_q;
	assign time_c[0]      = launch_time_q;
	assign target_c[0]    = launch_target_q;
	assign best_idx_c[0]  = '0;
	assign best_time_c[0] = launch_best_time_q;
	assign fired_c[0]     = launch_fired_q;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		evs_cell #(
			.SLOTS(SLOTS), .ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS), .IDX(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl_i      (ctl_c[i]),
			.id_i       (id_c[i]),
			.time_i     (time_c[i]),
			.target_i   (target_c[i]),
			.best_idx_i (best_idx_c[i]),
			.best_time_i(best_time_c[i]),
			.fired_i    (fired_c[i]),
			.ctl_o      (ctl_c[i+1]),
			.id_o       (id_c[i+1]),
			.time_o     (time_c[i+1]),
			.target_o   (target_c[i+1]),
			.best_idx_o (best_idx_c[i+1]),
			.best_time_o(best_time_c[i+1]),
			.fired_o    (fired_c[i+1])
		);
	end

	assign end_ctl   = ctl_c[SLOTS];
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_kind   = kind_t'(req.kind);

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.slot_index    = INDEX_W'(out_idx_q);
	assign rsp.next_time     = out_time_q;
	assign rsp.fired_id      = out_fired_q;
	assign rsp.pending_count = COUNT_W'(out_cnt_q);

	// sequencer: launch, collect at the end of the row, hand to output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_main_q  <= '0;
			next_sec_q   <= '0;
			cnt_q        <= '0;
			launch_ctl_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_HOLD) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_idx_q    <= '0;
						res_time_q   <= '0;
						res_fired_q  <= '0;
						if (req.kind <= K_HANDLE) begin
							launch_ctl_q <= '{active: 1'b1, op: in_kind, list: req.list_sel,
								pass2: 1'b0, found: 1'b0};
							launch_id_q        <= req.event_id;
							launch_time_q      <= req.event_time;
							launch_target_q    <= req.list_sel ? next_sec_q : next_main_q;
							launch_best_time_q <= '0;
							launch_fired_q     <= '0;
							state_q            <= S_RUN;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_RUN: begin
					if (end_ctl.active) begin
						// a handle that found its slot goes round again
						state_q <= (end_ctl.op == K_HANDLE && end_ctl.found && !end_ctl.pass2)
							? S_RUN : S_HOLD;
						case (end_ctl.op)
							K_SCHED: begin
								if (end_ctl.found) begin
									res_idx_q <= best_idx_c[SLOTS];
									cnt_q     <= cnt_q + 1'b1;
								end else begin
									res_status_q <= ST_FULL;
								end
							end
							K_REMOVE, K_ADJUST: begin
								if (end_ctl.found) begin
									res_idx_q <= best_idx_c[SLOTS];
									if (end_ctl.op == K_REMOVE && cnt_q != '0)
										cnt_q <= cnt_q - 1'b1;
								end else begin
									res_status_q <= ST_NOTFOUND;
								end
							end
							K_FIND: begin
								if (end_ctl.found) begin
									res_idx_q  <= best_idx_c[SLOTS];
									res_time_q <= best_time_c[SLOTS];
									if (end_ctl.list) next_sec_q <= best_idx_c[SLOTS];
									else next_main_q <= best_idx_c[SLOTS];
								end else begin
									res_status_q <= ST_EMPTY;
								end
							end
							K_HANDLE: begin
								res_idx_q <= target_c[SLOTS];
								if (!end_ctl.found) begin
									res_status_q <= ST_EMPTY;
								end else if (!end_ctl.pass2) begin
									// second walk subtracts the elapsed time
									launch_ctl_q <= '{active: 1'b1, op: end_ctl.op,
										list: end_ctl.list, pass2: 1'b1, found: end_ctl.found};
									launch_id_q        <= id_c[SLOTS];
									launch_time_q      <= time_c[SLOTS];
									launch_target_q    <= target_c[SLOTS];
									launch_best_time_q <= best_time_c[SLOTS];
									launch_fired_q     <= fired_c[SLOTS];
								end else begin
									res_time_q  <= best_time_c[SLOTS];
									res_fired_q <= fired_c[SLOTS];
									if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
								end
							end
							default: begin
							end
						endcase
					end else begin
						launch_ctl_q.active <= 1'b0;
					end
				end
				S_HOLD: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_idx_q    <= res_idx_q;
						out_time_q   <= res_time_q;
						out_fired_q  <= res_fired_q;
						out_cnt_q    <= cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a token only leaves the row while the sequencer waits for it
	a_end_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		end_ctl.active |-> state_q == S_RUN)
		else $error("token left the cell row outside the run state");

	// while a token is launched, the sequencer runs and no token leaves the row
	a_launch_run: assert property (@(posedge clk) disable iff (!arst_n)
		launch_ctl_q.active |-> state_q == S_RUN && !end_ctl.active)
		else $error("launch while another token is in flight");

	// pending count never exceeds the slots of both lists together (2*SLOTS)
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(2 * SLOTS))
		else $error("pending count above capacity");

endmodule

FILE: verif/tb_event_slot_scheduler_core.sv
`timescale 1ns / 1ps

module tb_event_slot_scheduler_core;
	import evs_pkg::*;

	localparam int SLOTS     = SLOTS_DEF;
	localparam int ID_BITS   = ID_BITS_DEF;
	localparam int TIME_BITS = TIME_BITS_DEF;
	localparam int WDOG_MAX  = 20000;
	localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
	localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

	typedef struct packed {
		logic [1:0]                  status;
		logic [4:0]                  slot_index;
		logic signed [TIME_BITS-1:0] next_time;
		logic [ID_BITS-1:0]          fired_id;
		logic [6:0]                  pending_count;
	} sched_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	int   idle_cycles = 0;
	bit   rsp_stall_en = 1'b1;

	evs_in_if  #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) req ();
	evs_out_if #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) rsp ();

	event_slot_scheduler_core #(.SLOTS(SLOTS), .ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always #4 clk = ~clk;

	// shadow copy of the slot tables
	logic                        sh_valid [2*SLOTS];
	logic signed [TIME_BITS-1:0] sh_time  [2*SLOTS];
	logic [ID_BITS-1:0]          sh_id    [2*SLOTS];
	int                          sh_next  [2];
	int                          sh_total;
	sched_rsp_t                  expected_rsps [$];

	function automatic logic signed [TIME_BITS-1:0] sat_minus(
		logic signed [TIME_BITS-1:0] a, logic signed [TIME_BITS-1:0] b);
		logic signed [TIME_BITS:0] d;
		d = {a[TIME_BITS-1], a} - {b[TIME_BITS-1], b};
		if (d > $signed({T_MAX[TIME_BITS-1], T_MAX})) return T_MAX;
		if (d < $signed({T_MIN[TIME_BITS-1], T_MIN})) return T_MIN;
		return d[TIME_BITS-1:0];
	endfunction

	// compute the response for one command and update the shadow tables
	function automatic sched_rsp_t predict_sched(logic [2:0] kind, logic lst,
		logic [ID_BITS-1:0] id, logic signed [TIME_BITS-1:0] t);
		sched_rsp_t r;
		int base, k, best, p;
		bit found;
		logic signed [TIME_BITS-1:0] el;
		r = '0;
		base = lst * SLOTS;
		case (kind)
			K_SCHED: begin
				r.status = ST_FULL;
				for (int i = 0; i < SLOTS; i++)
					if (!sh_valid[base+i]) begin
						sh_valid[base+i] = 1'b1;
						sh_id[base+i] = id;
						sh_time[base+i] = t;
						sh_total++;
						r.status = ST_OK;
						r.slot_index = 5'(i);
						break;
					end
			end
			K_REMOVE, K_ADJUST: begin
				k = -1;
				for (int i = 0; i < SLOTS && k < 0; i++) begin
					if (sh_valid[i] && sh_id[i] == id) k = i;
					else if (sh_valid[SLOTS+i] && sh_id[SLOTS+i] == id) k = SLOTS + i;
				end
				if (k < 0) r.status = ST_NOTFOUND;
				else begin
					if (kind == K_REMOVE) begin
						sh_valid[k] = 1'b0;
						if (sh_total > 0) sh_total--;
					end else sh_time[k] = t;
					r.slot_index = 5'(k % SLOTS);
				end
			end
			K_FIND: begin
				found = 0;
				best = 0;
				for (int i = 0; i < SLOTS; i++)
					if (sh_valid[base+i] && (!found || sh_time[base+i] < sh_time[base+best])) begin
						best = i;
						found = 1;
					end
				if (found) begin
					sh_next[lst] = best;
					r.slot_index = 5'(best);
					r.next_time = sh_time[base+best];
				end else r.status = ST_EMPTY;
			end
			K_HANDLE: begin
				p = sh_next[lst];
				r.slot_index = 5'(p);
				if (sh_valid[base+p]) begin
					el = sh_time[base+p];
					r.fired_id = sh_id[base+p];
					r.next_time = el;
					for (int i = 0; i < SLOTS; i++)
						if (sh_valid[base+i]) sh_time[base+i] = sat_minus(sh_time[base+i], el);
					sh_valid[base+p] = 1'b0;
					if (sh_total > 0) sh_total--;
				end else r.status = ST_EMPTY;
			end
			default: ;
		endcase
		r.pending_count = 7'(sh_total);
		return r;
	endfunction

	// gap of random length: mostly short, sometimes long
	function automatic int gap_len();
		int u;
		u = $urandom_range(0, 99);
		if (u < 40) return 0;
		if (u < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// send one command; the prediction is taken at acceptance
	// valid stays high into a zero gap and is dropped by the next gap or drain
	task automatic send_cmd(logic [2:0] kind, logic lst, logic [ID_BITS-1:0] id,
		logic signed [TIME_BITS-1:0] t);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.kind       <= kind;
		req.list_sel   <= lst;
		req.event_id   <= id;
		req.event_time <= t;
		do @(posedge clk); while (!req.ready);
		expected_rsps.push_back(predict_sched(kind, lst, id, t));
		@(negedge clk);
	endtask

	task automatic drain_rsps();
		req.valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic signed [TIME_BITS-1:0] rand_time();
		int u;
		u = $urandom_range(0, 9);
		if (u == 0) return T_MAX - TIME_BITS'($urandom_range(0, 3));
		if (u == 1) return T_MIN + TIME_BITS'($urandom_range(0, 3));
		if (u < 5) return TIME_BITS'({$urandom, $urandom});
		return $signed(TIME_BITS'($urandom_range(0, 1000)) - TIME_BITS'(500));
	endfunction

	// response stall pattern
	always @(negedge clk) begin
		if (!rsp_stall_en) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 99) < 65);
	end

	// compare each response with the oldest prediction
	always @(posedge clk) begin
		sched_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response status=%0d", $time, rsp.status);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, rsp.status);
					errors++;
				end
				if (rsp.slot_index !== want.slot_index) begin
					$display("%0t: slot_index exp %0d got %0d", $time, want.slot_index,
						rsp.slot_index);
					errors++;
				end
				if (rsp.next_time !== want.next_time) begin
					$display("%0t: next_time exp %0d got %0d", $time, want.next_time,
						rsp.next_time);
					errors++;
				end
				if (rsp.fired_id !== want.fired_id) begin
					$display("%0t: fired_id exp %0d got %0d", $time, want.fired_id, rsp.fired_id);
					errors++;
				end
				if (rsp.pending_count !== want.pending_count) begin
					$display("%0t: pending_count exp %0d got %0d", $time, want.pending_count,
						rsp.pending_count);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("tb_event_slot_scheduler_core: done, errors");
			$finish;
		end
	end

	// extremes, empty and stale cases, ties, saturation
	task automatic test_directed();
		send_cmd(K_FIND, 1'b0, 8'd0, '0);
		send_cmd(K_HANDLE, 1'b0, 8'd0, '0);
		send_cmd(K_REMOVE, 1'b0, 8'hFF, '0);
		send_cmd(K_ADJUST, 1'b1, 8'h00, T_MAX);
		send_cmd(3'd5, 1'b1, 8'hFF, T_MIN);
		send_cmd(3'd7, 1'b0, 8'h00, T_MAX);
		send_cmd(K_SCHED, 1'b0, 8'hFF, T_MAX);
		send_cmd(K_SCHED, 1'b0, 8'h00, T_MIN);
		send_cmd(K_SCHED, 1'b0, 8'h11, T_MIN);
		send_cmd(K_SCHED, 1'b1, 8'hFF, 48'sd5);
		send_cmd(K_FIND, 1'b0, 8'd0, '0);
		send_cmd(K_HANDLE, 1'b0, 8'd0, '0);
		send_cmd(K_HANDLE, 1'b0, 8'd0, '0);
		send_cmd(K_ADJUST, 1'b0, 8'hFF, T_MIN);
		send_cmd(K_REMOVE, 1'b0, 8'hFF, '0);
		send_cmd(K_REMOVE, 1'b0, 8'hFF, '0);
		send_cmd(K_FIND, 1'b1, 8'd0, '0);
		send_cmd(K_HANDLE, 1'b1, 8'd0, '0);
		drain_rsps();
	endtask

	// fill a list past full
	task automatic test_full_list();
		for (int i = 0; i <= SLOTS; i++) send_cmd(K_SCHED, 1'b1, i[7:0], 48'sd7);
		send_cmd(K_FIND, 1'b1, 8'd0, '0);
		send_cmd(K_HANDLE, 1'b1, 8'd0, '0);
		send_cmd(K_SCHED, 1'b1, 8'hAA, T_MIN);
		drain_rsps();
	endtask

	// random mix; ids from a small pool so lookups hit
	task automatic test_random(int n);
		logic [2:0] k;
		int u;
		for (int i = 0; i < n; i++) begin
			u = $urandom_range(0, 99);
			if (u < 30) k = K_SCHED;
			else if (u < 42) k = K_REMOVE;
			else if (u < 52) k = K_ADJUST;
			else if (u < 72) k = K_FIND;
			else if (u < 97) k = K_HANDLE;
			else k = 3'($urandom_range(5, 7));
			send_cmd(k, 1'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
				rand_time());
			if (i == n / 2) drain_rsps();
			if (i == n / 4) rsp_stall_en = 1'b0;
			if (i == n / 3) rsp_stall_en = 1'b1;
		end
		drain_rsps();
	endtask

	initial begin
		req.valid      = 1'b0;
		req.kind       = '0;
		req.list_sel   = 1'b0;
		req.event_id   = '0;
		req.event_time = '0;
		rsp.ready      = 1'b0;
		for (int i = 0; i < 2*SLOTS; i++) begin
			sh_valid[i] = 1'b0;
			sh_time[i]  = '0;
			sh_id[i]    = '0;
		end
		sh_next[0] = 0;
		sh_next[1] = 0;
		sh_total   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_list();
		test_random(1650);
		if (errors == 0) $display("tb_event_slot_scheduler_core: done, clean");
		else $display("tb_event_slot_scheduler_core: done, errors");
		$finish;
	end

endmodule

FILE: event_slot_scheduler_core.f
hdl/evs_pkg.sv
hdl/evs_in_if.sv
hdl/evs_out_if.sv
hdl/evs_cell.sv
hdl/event_slot_scheduler_core.sv
verif/tb_event_slot_scheduler_core.sv
